[hdl/deq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// No dependencies; every other file in hdl/ uses this package.
package deq_pkg;

  localparam int DATA_W      = 32;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

endpackage

[hdl/deq_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the queue's operation and result words.
// Depends on deq_pkg for field widths.
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic signed [deq_pkg::DATA_W-1:0]   value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface deq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [deq_pkg::DATA_W-1:0]     front_value;
  logic signed [deq_pkg::DATA_W-1:0]     back_value;
  logic [deq_pkg::COUNT_OUT_W-1:0]       count;
  logic                                  empty_res;
  logic [1:0]                            error;

  modport source (output valid, front_value, back_value, count, empty_res, error,
                  input ready);
  modport sink   (input valid, front_value, back_value, count, empty_res, error,
                  output ready);
endinterface

[hdl/deq_ring.sv]
`timescale 1ns / 1ps
// Ring storage of the queue: one write port, one read port, registered read data.
// Depends on deq_pkg for the element width.
module deq_ring #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH)-1:0]           waddr,
  input  logic signed [deq_pkg::DATA_W-1:0]  wdata,
  input  logic                               re,
  input  logic [$clog2(DEPTH)-1:0]           raddr,
  output logic signed [deq_pkg::DATA_W-1:0]  rdata
);

  logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/deq_ctrl.sv]
`timescale 1ns / 1ps
// Queue control: front index, count, cached end values, pop sequencer and result register.
// Depends on deq_pkg and the channel interfaces in deq_if.sv; drives deq_ring.
module deq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  deq_in_if.sink                             in_ch,
  deq_out_if.source                          out_ch,
  output logic                               mem_we,
  output logic [$clog2(DEPTH)-1:0]           mem_waddr,
  output logic signed [deq_pkg::DATA_W-1:0]  mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(DEPTH)-1:0]           mem_raddr,
  input  logic signed [deq_pkg::DATA_W-1:0]  mem_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int DW = deq_pkg::DATA_W;
  localparam int OW = deq_pkg::COUNT_OUT_W;

  deq_pkg::state_t state_r, state_nxt;

  logic [IW-1:0]        first_r, first_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic signed [DW-1:0] front_r, front_nxt;
  logic signed [DW-1:0] back_r, back_nxt;
  logic                 take_front_r, take_front_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_front_r, out_back_r;
  logic [CW-1:0]        out_count_r;
  deq_pkg::err_t        out_err_r;
  deq_pkg::err_t        err_nxt;
  logic                 load_out;

  logic                 accept;
  logic                 is_empty, is_full;
  logic [IW-1:0]        first_inc, first_dec;
  logic [SW-1:0]        tail_sum, lastm1_sum;
  logic [IW-1:0]        push_pos, lastm1_pos;
  logic [CW+OW-1:0]     count_ext;

  assign in_ch.ready = (state_r == deq_pkg::ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));

  assign first_inc = (first_r == IW'(DEPTH - 1)) ? '0 : first_r + IW'(1);
  assign first_dec = (first_r == '0) ? IW'(DEPTH - 1) : first_r - IW'(1);

  // Back slot for push, and the slot before the back for pop; used sums stay below 2*DEPTH.
  assign tail_sum   = SW'(first_r) + SW'(count_r);
  assign push_pos   = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign lastm1_sum = tail_sum - SW'(2);
  assign lastm1_pos = (lastm1_sum >= SW'(DEPTH)) ? IW'(lastm1_sum - SW'(DEPTH))
                                                 : IW'(lastm1_sum);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      deq_pkg::ST_IDLE: begin
        if (accept && count_r > CW'(1) &&
            (deq_pkg::kind_t'(in_ch.kind) == deq_pkg::KIND_POP_FRONT ||
             deq_pkg::kind_t'(in_ch.kind) == deq_pkg::KIND_POP_BACK)) begin
          state_nxt = deq_pkg::ST_POP;
        end
      end
      deq_pkg::ST_POP: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, memory requests and result loading
  always_comb begin
    first_nxt      = first_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    take_front_nxt = take_front_r;
    err_nxt        = deq_pkg::ERR_OK;
    load_out       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = push_pos;
    mem_wdata      = in_ch.value;
    mem_re         = 1'b0;
    mem_raddr      = first_inc;

    case (state_r)
      deq_pkg::ST_IDLE: begin
        if (accept) begin
          case (deq_pkg::kind_t'(in_ch.kind))
            deq_pkg::KIND_PUSH_FRONT: begin
              load_out = 1'b1;
              if (is_full) begin
                err_nxt = deq_pkg::ERR_FULL;
              end else begin
                first_nxt = first_dec;
                count_nxt = count_r + CW'(1);
                mem_we    = 1'b1;
                mem_waddr = first_dec;
                front_nxt = in_ch.value;
                if (is_empty) begin
                  back_nxt = in_ch.value;
                end
              end
            end
            deq_pkg::KIND_PUSH_BACK: begin
              load_out = 1'b1;
              if (is_full) begin
                err_nxt = deq_pkg::ERR_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
                mem_we    = 1'b1;
                back_nxt  = in_ch.value;
                if (is_empty) begin
                  front_nxt = in_ch.value;
                end
              end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
              if (is_empty) begin
                load_out = 1'b1;
                err_nxt  = deq_pkg::ERR_EMPTY;
              end else begin
                count_nxt      = count_r - CW'(1);
                take_front_nxt = (deq_pkg::kind_t'(in_ch.kind) == deq_pkg::KIND_POP_FRONT);
                if (take_front_nxt) begin
                  first_nxt = first_inc;
                end
                if (count_r == CW'(1)) begin
                  // last element gone: report at once, ends read as zero
                  load_out  = 1'b1;
                  front_nxt = '0;
                  back_nxt  = '0;
                end else begin
                  // fetch the new end element, finish next cycle
                  mem_re    = 1'b1;
                  mem_raddr = take_front_nxt ? first_inc : lastm1_pos;
                end
              end
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
        end
      end
      deq_pkg::ST_POP: begin
        load_out = 1'b1;
        if (take_front_r) begin
          front_nxt = mem_rdata;
        end else begin
          back_nxt = mem_rdata;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= deq_pkg::ST_IDLE;
      first_r      <= '0;
      count_r      <= '0;
      front_r      <= '0;
      back_r       <= '0;
      take_front_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_r      <= first_nxt;
      count_r      <= count_nxt;
      front_r      <= front_nxt;
      back_r       <= back_nxt;
      take_front_r <= take_front_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_front_r <= (count_nxt == '0) ? '0 : front_nxt;
      out_back_r  <= (count_nxt == '0) ? '0 : back_nxt;
      out_count_r <= count_nxt;
      out_err_r   <= err_nxt;
    end
  end

  // Result count is reported modulo 32
  assign count_ext = {{OW{1'b0}}, out_count_r};

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.back_value  = out_back_r;
  assign out_ch.count       = count_ext[OW-1:0];
  assign out_ch.empty_res   = (out_count_r == '0);
  assign out_ch.error       = out_err_r;

endmodule

[hdl/double_ended_queue.sv]
`timescale 1ns / 1ps
// Top level of the double-ended queue: control and ring storage.
// Depends on deq_pkg, deq_if.sv, deq_ring and deq_ctrl.
//
//   channel   direction  handshake     word
//   in_if     sink       valid/ready   kind, value
//   out_if    source     valid/ready   front_value, back_value, count, empty_res, error
//
// A push, a pop on an empty queue or a pop of the last element loads the result
// register directly; other pops first wait for the ring's registered read data.
// The end values are cached in registers, so only pops read the ring.
// Reset clears the index and count; the ring needs no clearing pass.
// A stalled result holds in the output register; a new word is taken in the
// cycle the pending result is taken.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_if,
  deq_out_if.source out_if
);

  localparam int IW = $clog2(DEPTH);

  logic                               mem_we;
  logic [IW-1:0]                      mem_waddr;
  logic signed [deq_pkg::DATA_W-1:0]  mem_wdata;
  logic                               mem_re;
  logic [IW-1:0]                      mem_raddr;
  logic signed [deq_pkg::DATA_W-1:0]  mem_rdata;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  deq_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[hdl/deq_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the double-ended queue, bound to the top level.
// Depends on deq_pkg for the error codes.
module deq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [deq_pkg::DATA_W-1:0]  out_front_value,
  input logic signed [deq_pkg::DATA_W-1:0]  out_back_value,
  input logic [deq_pkg::COUNT_OUT_W-1:0]    out_count,
  input logic                               out_empty_res,
  input logic [1:0]                         out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_count == '0)
    else $error("empty flag with nonzero count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_front_value == '0 && out_back_value == '0)
    else $error("empty queue reports nonzero end value");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error == 2'(deq_pkg::ERR_FULL) |-> !out_empty_res)
    else $error("full error on an empty queue");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error == 2'(deq_pkg::ERR_OK) || out_error == 2'(deq_pkg::ERR_EMPTY) ||
                  out_error == 2'(deq_pkg::ERR_FULL))
    else $error("undefined error code");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_front_value (out_if.front_value),
  .out_back_value  (out_if.back_value),
  .out_count       (out_if.count),
  .out_empty_res   (out_if.empty_res),
  .out_error       (out_if.error)
);
